>>> rtl/hcb_pkg.sv
// Types, constants and mod-26 and mod-3 helper functions shared by the Hill cipher block.
package hcb_pkg;

    localparam int LETTER_W    = 5;
    localparam int KEY_W       = 45;
    localparam int BSIZE_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int MODULUS     = 26;
    localparam int RECIP       = 2521;
    localparam int RECIP_SHIFT = 16;

    localparam logic [KEY_W-1:0]     KEY_RESET   = 45'h100_0010_0001;
    localparam logic [BSIZE_W-1:0]   BSIZE_RESET = 2'd2;
    localparam logic [BSIZE_W-1:0]   BSIZE_ORDER3 = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_KEY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BSIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE  = 2'd2;

    typedef logic [LETTER_W-1:0] letter_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_COF,
        ST_DET,
        ST_INV,
        ST_SCALE,
        ST_ROW
    } hcb_state_t;

    typedef struct packed {
        letter_t acc;
        letter_t a;
        letter_t b;
    } hcb_mac_op_t;

    function automatic letter_t mod26(input letter_t x);
        mod26 = (x >= letter_t'(MODULUS)) ? x - letter_t'(MODULUS) : x;
    endfunction

    function automatic letter_t neg26(input letter_t x);
        neg26 = (x == '0) ? '0 : letter_t'(MODULUS) - x;
    endfunction

    function automatic logic [1:0] mod3_inc(input logic [1:0] x);
        mod3_inc = (x == 2'd2) ? 2'd0 : x + 2'd1;
    endfunction

    function automatic letter_t inv26(input letter_t x);
        case (x)
            5'd1:    inv26 = 5'd1;
            5'd3:    inv26 = 5'd9;
            5'd5:    inv26 = 5'd21;
            5'd7:    inv26 = 5'd15;
            5'd9:    inv26 = 5'd3;
            5'd11:   inv26 = 5'd19;
            5'd15:   inv26 = 5'd7;
            5'd17:   inv26 = 5'd23;
            5'd19:   inv26 = 5'd11;
            5'd21:   inv26 = 5'd5;
            5'd23:   inv26 = 5'd17;
            5'd25:   inv26 = 5'd25;
            default: inv26 = 5'd0;
        endcase
    endfunction

endpackage

>>> rtl/hcb_letter_if.sv
// Valid/ready channel carrying one input letter per transaction.
interface hcb_letter_if;
    logic              valid;
    logic              ready;
    hcb_pkg::letter_t  letter_in;
    logic              final_letter;

    modport source (output valid, output letter_in, output final_letter, input ready);
    modport sink   (input valid, input letter_in, input final_letter, output ready);
endinterface

>>> rtl/hcb_result_if.sv
// Valid/ready channel carrying one transformed letter per transaction.
interface hcb_result_if;
    logic              valid;
    logic              ready;
    hcb_pkg::letter_t  letter_out;
    logic              block_end;
    logic              key_error;

    modport source (output valid, output letter_out, output block_end, output key_error,
                    input ready);
    modport sink   (input valid, input letter_out, input block_end, input key_error,
                    output ready);
endinterface

>>> rtl/hcb_mac.sv
// Shared multiply-accumulate unit: (acc + a * b) mod 26 for operands below 26.
module hcb_mac
(
    input  hcb_pkg::hcb_mac_op_t op,
    output hcb_pkg::letter_t     res
);

    logic [9:0]  sum;
    logic [20:0] prod;
    logic [4:0]  quo;
    logic [9:0]  rem;

    always_comb
    begin
        sum  = 10'(op.acc) + 10'(op.a) * 10'(op.b);
        prod = 21'(sum) * 21'(hcb_pkg::RECIP);
        quo  = 5'(prod >> hcb_pkg::RECIP_SHIFT);
        rem  = sum - 10'(quo) * 10'(hcb_pkg::MODULUS);
        res  = rem[4:0];
    end

endmodule

>>> rtl/hill_cipher_block_mod26.sv
// Top level of the Hill cipher block: letter gathering, key sequencer and output register.
//
// Letters are taken one per cycle while the block is idle. A letter that completes a block
// (or carries final_letter) starts the block's product of n rows on the shared mod-26
// multiply-accumulate unit, n being 2 or 3 (with a singular key when decrypting, each result
// is a zero letter flagged with key_error), and the block takes letters again once the last
// result is in the output register, so no new letters are taken while a block is in work.
// The first block after a write to the key, block size or mode register also rebuilds the
// applied matrix: encrypting copies the reduced key, and decrypting works on the same unit
// through cofactors (order 3 only), determinant, inverse lookup and scaling; a singular key
// skips the scaling. Results stall in the output register under back-pressure without
// losing work.
module hill_cipher_block_mod26
#(
    parameter int MAX_ORDER = 3
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    hcb_letter_if.sink                          letters,
    hcb_result_if.source                        results,
    input  logic                                wr_en,
    input  logic [hcb_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [hcb_pkg::KEY_W-1:0]           wr_data
);

    localparam int IDX_W = (MAX_ORDER > 2) ? 2 : 1;

    hcb_pkg::hcb_state_t state_reg, state_next;

    logic [hcb_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [hcb_pkg::BSIZE_W-1:0] bsize_reg, bsize_next;
    logic                        mode_reg, mode_next;
    hcb_pkg::letter_t            blk_reg [MAX_ORDER];
    hcb_pkg::letter_t            blk_next [MAX_ORDER];
    logic [IDX_W-1:0]            fill_reg, fill_next;
    hcb_pkg::letter_t            m_reg [MAX_ORDER][MAX_ORDER];
    hcb_pkg::letter_t            m_next [MAX_ORDER][MAX_ORDER];
    logic                        dirty_reg, dirty_next;
    logic                        err_reg, err_next;
    hcb_pkg::letter_t            det_reg, det_next;
    hcb_pkg::letter_t            inv_reg, inv_next;
    logic [IDX_W-1:0]            i_reg, i_next;
    logic [IDX_W-1:0]            j_reg, j_next;
    logic                        ph_reg, ph_next;
    hcb_pkg::letter_t            acc_reg, acc_next;
    logic                        out_valid_reg, out_valid_next;
    hcb_pkg::letter_t            out_letter_reg, out_letter_next;
    logic                        out_end_reg, out_end_next;
    logic                        out_err_reg, out_err_next;

    hcb_pkg::letter_t     kred [3][3];
    hcb_pkg::hcb_mac_op_t mac_op;
    hcb_pkg::letter_t     mac_res;

    logic             order3;
    logic [IDX_W-1:0] n_last;
    logic             slot_free;
    logic             in_fire;
    logic             flush;
    logic             i_last;
    logic             j_last;
    logic             cof_last;
    logic             row_emit;
    logic [1:0]       ci, cj, r1, r2, c1, c2;

    hcb_mac u_mac
    (
        .op  (mac_op),
        .res (mac_res)
    );

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                kred[r][c] = hcb_pkg::mod26(key_reg[5*(3*r+c) +: 5]);
            end
        end
    end

    assign order3    = (bsize_reg == hcb_pkg::BSIZE_ORDER3) && (MAX_ORDER >= 3);
    assign n_last    = order3 ? IDX_W'(2) : IDX_W'(1);
    assign slot_free = !out_valid_reg || results.ready;
    assign in_fire   = letters.valid && letters.ready;
    assign flush     = in_fire && ((fill_reg == n_last) || letters.final_letter);
    assign i_last    = (i_reg == n_last);
    assign j_last    = (j_reg == n_last);
    assign cof_last  = ph_reg && (2'(i_reg) == 2'd2) && (2'(j_reg) == 2'd2);
    assign row_emit  = (state_reg == hcb_pkg::ST_ROW) && (err_reg || j_last) && slot_free;

    assign ci = 2'(i_reg);
    assign cj = 2'(j_reg);
    assign r1 = hcb_pkg::mod3_inc(cj);
    assign r2 = hcb_pkg::mod3_inc(r1);
    assign c1 = hcb_pkg::mod3_inc(ci);
    assign c2 = hcb_pkg::mod3_inc(c1);

    assign letters.ready      = (state_reg == hcb_pkg::ST_IDLE);
    assign results.valid      = out_valid_reg;
    assign results.letter_out = out_letter_reg;
    assign results.block_end  = out_end_reg;
    assign results.key_error  = out_err_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hcb_pkg::ST_IDLE:
            begin
                if (flush)
                begin
                    state_next = dirty_reg ? hcb_pkg::ST_PREP : hcb_pkg::ST_ROW;
                end
            end
            hcb_pkg::ST_PREP:
            begin
                if (!mode_reg)
                begin
                    state_next = hcb_pkg::ST_ROW;
                end
                else if (order3)
                begin
                    state_next = hcb_pkg::ST_COF;
                end
                else
                begin
                    state_next = hcb_pkg::ST_DET;
                end
            end
            hcb_pkg::ST_COF:
            begin
                if (cof_last)
                begin
                    state_next = hcb_pkg::ST_DET;
                end
            end
            hcb_pkg::ST_DET:
            begin
                if (i_last)
                begin
                    state_next = hcb_pkg::ST_INV;
                end
            end
            hcb_pkg::ST_INV:
            begin
                state_next = (hcb_pkg::inv26(det_reg) == '0) ? hcb_pkg::ST_ROW
                                                              : hcb_pkg::ST_SCALE;
            end
            hcb_pkg::ST_SCALE:
            begin
                if (i_last && j_last)
                begin
                    state_next = hcb_pkg::ST_ROW;
                end
            end
            hcb_pkg::ST_ROW:
            begin
                if (row_emit && i_last)
                begin
                    state_next = hcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hcb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        key_next        = key_reg;
        bsize_next      = bsize_reg;
        mode_next       = mode_reg;
        blk_next        = blk_reg;
        fill_next       = fill_reg;
        m_next          = m_reg;
        dirty_next      = dirty_reg;
        err_next        = err_reg;
        det_next        = det_reg;
        inv_next        = inv_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        ph_next         = ph_reg;
        acc_next        = acc_reg;
        out_valid_next  = out_valid_reg;
        out_letter_next = out_letter_reg;
        out_end_next    = out_end_reg;
        out_err_next    = out_err_reg;
        mac_op          = '0;

        if (out_valid_reg && results.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hcb_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    blk_next[fill_reg] = hcb_pkg::mod26(letters.letter_in);
                    if (flush)
                    begin
                        fill_next = '0;
                        i_next    = '0;
                        j_next    = '0;
                        ph_next   = 1'b0;
                    end
                    else
                    begin
                        fill_next = fill_reg + IDX_W'(1);
                    end
                end
            end
            hcb_pkg::ST_PREP:
            begin
                i_next  = '0;
                j_next  = '0;
                ph_next = 1'b0;
                if (!mode_reg)
                begin
                    for (int r = 0; r < MAX_ORDER; r++)
                    begin
                        for (int c = 0; c < MAX_ORDER; c++)
                        begin
                            m_next[r][c] = kred[r][c];
                        end
                    end
                    err_next   = 1'b0;
                    dirty_next = 1'b0;
                end
                else if (!order3)
                begin
                    m_next[0][0] = kred[1][1];
                    m_next[0][1] = hcb_pkg::neg26(kred[0][1]);
                    m_next[1][0] = hcb_pkg::neg26(kred[1][0]);
                    m_next[1][1] = kred[0][0];
                end
            end
            hcb_pkg::ST_COF:
            begin
                if (!ph_reg)
                begin
                    mac_op   = '{acc: '0, a: kred[r1][c1], b: kred[r2][c2]};
                    acc_next = mac_res;
                    ph_next  = 1'b1;
                end
                else
                begin
                    mac_op = '{acc: acc_reg, a: hcb_pkg::neg26(kred[r1][c2]),
                               b: kred[r2][c1]};
                    m_next[i_reg][j_reg] = mac_res;
                    ph_next = 1'b0;
                    if (cof_last)
                    begin
                        i_next = '0;
                        j_next = '0;
                    end
                    else if (cj == 2'd2)
                    begin
                        j_next = '0;
                        i_next = i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end
            hcb_pkg::ST_DET:
            begin
                mac_op = '{acc: (i_reg == '0) ? '0 : acc_reg, a: kred[0][ci],
                           b: m_reg[i_reg][0]};
                if (i_last)
                begin
                    det_next = mac_res;
                    i_next   = '0;
                end
                else
                begin
                    acc_next = mac_res;
                    i_next   = i_reg + IDX_W'(1);
                end
            end
            hcb_pkg::ST_INV:
            begin
                inv_next = hcb_pkg::inv26(det_reg);
                if (hcb_pkg::inv26(det_reg) == '0)
                begin
                    err_next   = 1'b1;
                    dirty_next = 1'b0;
                end
                else
                begin
                    err_next = 1'b0;
                end
                i_next = '0;
                j_next = '0;
            end
            hcb_pkg::ST_SCALE:
            begin
                mac_op = '{acc: '0, a: m_reg[i_reg][j_reg], b: inv_reg};
                m_next[i_reg][j_reg] = mac_res;
                if (j_last)
                begin
                    j_next = '0;
                    if (i_last)
                    begin
                        i_next     = '0;
                        dirty_next = 1'b0;
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            hcb_pkg::ST_ROW:
            begin
                mac_op = '{acc: (j_reg == '0) ? '0 : acc_reg, a: m_reg[i_reg][j_reg],
                           b: blk_reg[j_reg]};
                if (!err_reg && !j_last)
                begin
                    acc_next = mac_res;
                    j_next   = j_reg + IDX_W'(1);
                end
                else if (row_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_letter_next = err_reg ? '0 : mac_res;
                    out_end_next    = i_last;
                    out_err_next    = err_reg;
                    j_next          = '0;
                    if (i_last)
                    begin
                        i_next    = '0;
                        fill_next = '0;
                        for (int k = 0; k < MAX_ORDER; k++)
                        begin
                            blk_next[k] = '0;
                        end
                    end
                    else
                    begin
                        i_next = i_reg + IDX_W'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (wr_en)
        begin
            case (wr_index)
                hcb_pkg::REG_KEY:
                begin
                    key_next   = wr_data;
                    dirty_next = 1'b1;
                end
                hcb_pkg::REG_BSIZE:
                begin
                    bsize_next = wr_data[hcb_pkg::BSIZE_W-1:0];
                    fill_next  = '0;
                    for (int k = 0; k < MAX_ORDER; k++)
                    begin
                        blk_next[k] = '0;
                    end
                    dirty_next = 1'b1;
                end
                hcb_pkg::REG_MODE:
                begin
                    mode_next  = wr_data[0];
                    dirty_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hcb_pkg::ST_IDLE;
            key_reg       <= hcb_pkg::KEY_RESET;
            bsize_reg     <= hcb_pkg::BSIZE_RESET;
            mode_reg      <= 1'b0;
            for (int k = 0; k < MAX_ORDER; k++)
            begin
                blk_reg[k] <= '0;
            end
            fill_reg      <= '0;
            dirty_reg     <= 1'b1;
            err_reg       <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            ph_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            key_reg       <= key_next;
            bsize_reg     <= bsize_next;
            mode_reg      <= mode_next;
            blk_reg       <= blk_next;
            fill_reg      <= fill_next;
            dirty_reg     <= dirty_next;
            err_reg       <= err_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ph_reg        <= ph_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg          <= m_next;
        det_reg        <= det_next;
        inv_reg        <= inv_next;
        acc_reg        <= acc_next;
        out_letter_reg <= out_letter_next;
        out_end_reg    <= out_end_next;
        out_err_reg    <= out_err_next;
    end

endmodule

>>> tb/tb_hill_cipher_block_mod26.sv
`timescale 1ns / 1ps
// Testbench for hill_cipher_block_mod26: directed and random letters checked against a predictor.
module tb_hill_cipher_block_mod26;
    import hcb_pkg::*;

    localparam int SETTLE_CYCLES = 50;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_LETTERS = 60;
    localparam int NUM_PHASES    = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

    localparam logic [KEY_W-1:0] KEY_ONES   = '1;
    localparam logic [KEY_W-1:0] KEY_ORDER3 = {5'd15, 5'd17, 5'd20, 5'd10, 5'd16, 5'd13,
                                               5'd1, 5'd24, 5'd6};
    localparam logic [KEY_W-1:0] KEY_WIDE2  = {5'd0, 5'd0, 5'd0, 5'd0, 5'd31, 5'd2,
                                               5'd0, 5'd3, 5'd29};

    typedef struct {
        letter_t letter;
        logic    block_end;
        logic    key_error;
    } cipher_out_t;

    class hill_tracker;
        logic [KEY_W-1:0]   key_reg;
        logic [BSIZE_W-1:0] bsize;
        logic               decrypt;
        int unsigned        held[3];
        int unsigned        fill;
        int unsigned        mat[3][3];
        cipher_out_t        due[$];
        int                 errors;
        int                 accepted;
        int                 checked;
        int                 blocks;
        int                 flagged;

        function new();
            key_reg  = KEY_RESET;
            bsize    = BSIZE_RESET;
            decrypt  = 1'b0;
            errors   = 0;
            accepted = 0;
            checked  = 0;
            blocks   = 0;
            flagged  = 0;
            clear_block();
        endfunction

        function void clear_block();
            foreach (held[i])
                held[i] = 0;
            fill = 0;
        endfunction

        function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
            case (idx)
                REG_KEY:   key_reg = data;
                REG_BSIZE:
                begin
                    bsize = data[BSIZE_W-1:0];
                    clear_block();
                end
                REG_MODE:  decrypt = data[0];
                default:   ;
            endcase
        endfunction

        function bit build_matrix(int unsigned n);
            int unsigned k[3][3];
            int unsigned adj[3][3];
            int unsigned det;
            int unsigned inv;
            int unsigned i;
            int unsigned j;
            int unsigned x;
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                begin
                    k[i][j]   = key_reg[5*(3*i+j) +: 5] % MODULUS;
                    adj[i][j] = 0;
                    mat[i][j] = 0;
                end
            if (!decrypt)
            begin
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++)
                        mat[i][j] = k[i][j];
                return 1'b1;
            end
            if (n == 2)
            begin
                adj[0][0] = k[1][1];
                adj[0][1] = (MODULUS - k[0][1]) % MODULUS;
                adj[1][0] = (MODULUS - k[1][0]) % MODULUS;
                adj[1][1] = k[0][0];
            end
            else
            begin
                for (i = 0; i < 3; i++)
                    for (j = 0; j < 3; j++)
                        adj[i][j] = (k[(j+1)%3][(i+1)%3] * k[(j+2)%3][(i+2)%3]
                                     + MODULUS * MODULUS
                                     - k[(j+1)%3][(i+2)%3] * k[(j+2)%3][(i+1)%3]) % MODULUS;
            end
            det = 0;
            for (i = 0; i < n; i++)
                det += k[0][i] * adj[i][0];
            det = det % MODULUS;
            inv = 0;
            for (x = 1; x < MODULUS; x++)
                if (inv == 0 && (det * x) % MODULUS == 1)
                    inv = x;
            if (inv == 0)
                return 1'b0;
            for (i = 0; i < n; i++)
                for (j = 0; j < n; j++)
                    mat[i][j] = (adj[i][j] * inv) % MODULUS;
            return 1'b1;
        endfunction

        function void note_letter(letter_t l, logic fin);
            int unsigned n;
            int unsigned acc;
            int unsigned i;
            int unsigned j;
            bit          ok;
            cipher_out_t r;
            accepted++;
            n = (bsize == BSIZE_ORDER3) ? 3 : 2;
            if (fill >= n)
                fill = 0;
            held[fill] = l % MODULUS;
            fill++;
            if (fill < n && !fin)
                return;
            ok = build_matrix(n);
            for (i = 0; i < n; i++)
            begin
                acc = 0;
                for (j = 0; j < n; j++)
                    if (j < fill)
                        acc += mat[i][j] * held[j];
                r.letter    = ok ? letter_t'(acc % MODULUS) : '0;
                r.block_end = (i == n - 1);
                r.key_error = !ok;
                due.push_back(r);
            end
            blocks++;
            if (!ok)
                flagged++;
            clear_block();
        endfunction

        function void check_letter(letter_t l, logic be, logic ke);
            cipher_out_t e;
            checked++;
            if (due.size() == 0)
            begin
                $error("unexpected result: letter_out %0d block_end %0b key_error %0b", l, be, ke);
                errors++;
                return;
            end
            e = due.pop_front();
            if (l !== e.letter)
            begin
                $error("letter_out: expected %0d, got %0d", e.letter, l);
                errors++;
            end
            if (be !== e.block_end)
            begin
                $error("block_end: expected %0b, got %0b", e.block_end, be);
                errors++;
            end
            if (ke !== e.key_error)
            begin
                $error("key_error: expected %0b, got %0b", e.key_error, ke);
                errors++;
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 wr_en;
    logic [CFG_IDX_W-1:0] wr_index;
    logic [KEY_W-1:0]     wr_data;

    hcb_letter_if letters();
    hcb_result_if results();

    hill_tracker tracker;
    int          gap_pct = 0;
    int          stall_pct = 0;
    int          hold_left = 0;
    bit          hold_request = 1'b0;
    int          cfg_writes = 0;

    hill_cipher_block_mod26 u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .letters  (letters),
        .results  (results),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("hill_cipher_block_mod26 regression: fail");
        $finish;
    end

    initial
    begin
        results.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (results.valid && results.ready)
                tracker.check_letter(results.letter_out, results.block_end, results.key_error);
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                results.ready <= 1'b0;
            end
            else
                results.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [KEY_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        tracker.load_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic send_letter(letter_t l, logic fin);
        if ($urandom_range(0, 99) < gap_pct)
        begin
            letters.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < gap_pct);
        end
        letters.valid        <= 1'b1;
        letters.letter_in    <= l;
        letters.final_letter <= fin;
        do
            @(posedge clk);
        while (!letters.ready);
        tracker.note_letter(l, fin);
    endtask

    // drop valid, wait for every expected transaction, then let the block go quiet
    task automatic settle(int extra);
        letters.valid <= 1'b0;
        @(posedge clk);
        while (tracker.due.size() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    function automatic letter_t pick_letter();
        if ($urandom_range(0, 7) == 0)
            return letter_t'($urandom_range(26, 31));
        return letter_t'($urandom_range(0, 25));
    endfunction

    initial
    begin
        int               p;
        int               i;
        int               e;
        logic [KEY_W-1:0] key_val;
        logic [KEY_W-1:0] data;

        tracker              = new();
        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = REG_KEY;
        wr_data              = '0;
        letters.valid        = 1'b0;
        letters.letter_in    = '0;
        letters.final_letter = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        send_letter(5'd0, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd26, 1'b1);
        send_letter(5'd7, 1'b1);
        settle(SETTLE_CYCLES);

        write_reg(REG_KEY, KEY_WIDE2);
        write_reg(REG_MODE, KEY_W'(1));
        send_letter(5'd19, 1'b0);
        send_letter(5'd4, 1'b0);
        send_letter(5'd13, 1'b1);
        settle(SETTLE_CYCLES);

        write_reg(REG_KEY, KEY_ONES);
        send_letter(5'd3, 1'b0);
        send_letter(5'd4, 1'b1);
        send_letter(5'd9, 1'b1);
        settle(SETTLE_CYCLES);

        write_reg(REG_MODE, KEY_W'(0));
        send_letter(5'd1, 1'b0);
        send_letter(5'd2, 1'b0);
        settle(SETTLE_CYCLES);

        write_reg(REG_KEY, KEY_ORDER3);
        write_reg(REG_BSIZE, KEY_W'(BSIZE_ORDER3));
        write_reg(REG_MODE, KEY_W'(1));
        send_letter(5'd0, 1'b0);
        send_letter(5'd2, 1'b0);
        send_letter(5'd19, 1'b0);
        send_letter(5'd31, 1'b0);
        send_letter(5'd0, 1'b1);
        settle(SETTLE_CYCLES);

        write_reg(REG_MODE, KEY_W'(0));
        send_letter(5'd25, 1'b0);
        send_letter(5'd25, 1'b0);
        send_letter(5'd25, 1'b1);
        send_letter(5'd11, 1'b0);
        settle(SETTLE_CYCLES);

        write_reg(REG_BSIZE, KEY_W'(0));
        send_letter(5'd5, 1'b0);
        send_letter(5'd6, 1'b0);
        settle(SETTLE_CYCLES);

        write_reg(REG_NONE, KEY_ONES);
        write_reg(REG_BSIZE, KEY_W'(1));
        send_letter(5'd12, 1'b1);
        settle(SETTLE_CYCLES);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case ((p + p / 4) % 4)
                0:
                begin
                    gap_pct   = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    gap_pct   = 59;
                    stall_pct = 0;
                end
                2:
                begin
                    gap_pct   = 0;
                    stall_pct = 59;
                end
                default:
                begin
                    gap_pct   = 23;
                    stall_pct = 23;
                end
            endcase
            if (p == 0)
                key_val = '0;
            else if (p == 1)
                key_val = KEY_ONES;
            else
                for (e = 0; e < 9; e++)
                    key_val[5*e +: 5] = ($urandom_range(0, 7) == 0) ?
                                        5'($urandom_range(26, 31)) : 5'($urandom_range(0, 25));
            write_reg(REG_KEY, key_val);
            data      = KEY_W'({$urandom(), $urandom()});
            data[1:0] = 2'(p % 4);
            write_reg(REG_BSIZE, data);
            data    = KEY_W'({$urandom(), $urandom()});
            data[0] = p[2] ^ p[0];
            write_reg(REG_MODE, data);
            if (p == 0)
                hold_request = 1'b1;
            for (i = 0; i < PHASE_LETTERS; i++)
            begin
                if (i == PHASE_LETTERS / 2)
                    settle(0);
                send_letter(pick_letter(), $urandom_range(0, 5) == 0);
            end
            settle(SETTLE_CYCLES);
        end

        if (tracker.due.size() != 0)
        begin
            $error("%0d expected results never arrived", tracker.due.size());
            tracker.errors++;
        end
        $display("Sent %0d letters over %0d register writes; %0d blocks, %0d with a singular key.",
                 tracker.accepted, cfg_writes, tracker.blocks, tracker.flagged);
        $display("Checked %0d result letters, %0d mismatches.", tracker.checked, tracker.errors);
        if (tracker.errors == 0)
            $display("hill_cipher_block_mod26 regression: pass");
        else
            $display("hill_cipher_block_mod26 regression: fail");
        $finish;
    end

endmodule
